/* hdl/idcf_pkg.sv */
// Package for the IMU datagram CRC framer: identifier codes, CRC constants, config indexes.
// No dependencies.
package idcf_pkg;
	localparam logic [7:0] ID_SHORT = 8'h90;
	localparam logic [7:0] ID_FULL = 8'h93;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
	localparam logic [6:0] MIN_LEN = 7'd5;

	localparam logic [1:0] REG_LEN_SHORT = 2'd0;
	localparam logic [1:0] REG_LEN_FULL = 2'd1;
	localparam logic [1:0] REG_DUMMY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_CRC,
		ST_CHECK,
		ST_EMIT
	} scan_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic kind;
		logic last;
	} out_item_t;

	function automatic logic [31:0] crc_bit(input logic [31:0] crc);
		crc_bit = crc[31] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
	endfunction
endpackage

/* hdl/idcf_in_fifo.sv */
// Input front: short queue of received bytes ahead of the scanner.
// Depends on nothing but its parameters.
module idcf_in_fifo #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [7:0] wr_data,
	output logic full,
	input logic rd_en,
	output logic [7:0] rd_data,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);
	logic [7:0] mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign full = (wp_q[AW-1:0] == rp_q[AW-1:0]) && (wp_q[AW] != rp_q[AW]);
	assign empty = (wp_q == rp_q);
	assign rd_data = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en && !full) wp_q <= wp_q + 1'b1;
			if (rd_en && !empty) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

/* hdl/idcf_out_fifo.sv */
// Output side: queue of result bytes towards the consumer.
// Depends on idcf_pkg for the result item type.
module idcf_out_fifo
	import idcf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input out_item_t wr_data,
	output logic full,
	input logic rd_en,
	output out_item_t rd_data,
	output logic empty
);
	localparam int AW = $clog2(DEPTH);
	out_item_t mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign full = (wp_q[AW-1:0] == rp_q[AW-1:0]) && (wp_q[AW] != rp_q[AW]);
	assign empty = (wp_q == rp_q);
	assign rd_data = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en && !full) wp_q <= wp_q + 1'b1;
			if (rd_en && !empty) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

/* hdl/idcf_scanner.sv */
// Back end: byte ring, identifier scan, bit-serial CRC check and datagram emit.
// Depends on idcf_pkg.
module idcf_scanner
	import idcf_pkg::*;
#(
	parameter int MAX_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_avail,
	input logic [7:0] in_byte,
	output logic in_take,
	input logic [6:0] len_short,
	input logic [6:0] len_full,
	input logic [2:0] dummy_cnt,
	output logic out_push,
	output out_item_t out_item,
	input logic out_full,
	output logic busy
);
	localparam int AW = $clog2(MAX_BYTES);
	localparam int FW = AW + 1;

	scan_state_t state_q, state_d;
	logic [7:0] ring_q [2**AW];
	logic [FW-1:0] fill_q;
	logic [AW-1:0] start_q;
	logic [31:0] crc_q;
	logic [FW-1:0] len_q;
	logic kind_q;
	logic [FW-1:0] idx_q;
	logic [2:0] bit_q;
	logic [7:0] rd_q;

	logic [FW-1:0] len_eff;
	logic [6:0] raw_len;
	logic head_is_id;
	logic [AW-1:0] rd_addr;
	logic [FW-1:0] crc_total;
	logic [FW-1:0] tail_begin;
	logic in_dummy;
	logic [FW-1:0] next_idx;
	logic [FW-1:0] next_data_idx;
	logic [7:0] crc_byte_v;
	logic [31:0] crc_in;

	// in the head step the registered ring read holds the oldest byte
	assign head_is_id = (rd_q == ID_SHORT) || (rd_q == ID_FULL);

	// effective length clamp
	always_comb begin
		raw_len = (rd_q == ID_FULL) ? len_full : len_short;
		if (raw_len < MIN_LEN) len_eff = FW'(MIN_LEN);
		else if (FW'(raw_len) > FW'(MAX_BYTES) || (FW < 7 && raw_len > 7'(MAX_BYTES)))
			len_eff = FW'(MAX_BYTES);
		else len_eff = FW'(raw_len);
	end

	assign crc_total = len_q + FW'(dummy_cnt);
	assign tail_begin = len_q - FW'(4);
	assign in_dummy = (idx_q >= tail_begin) && (idx_q < tail_begin + FW'(dummy_cnt));
	assign next_idx = idx_q + ((bit_q == 3'd7) ? FW'(1) : FW'(0));
	assign next_data_idx = (next_idx >= tail_begin + FW'(dummy_cnt)) ?
		next_idx - FW'(dummy_cnt) : next_idx;
	assign crc_byte_v = in_dummy ? 8'h00 : rd_q;
	assign crc_in = (bit_q == 3'd0) ? (crc_q ^ {crc_byte_v, 24'h0}) : crc_q;

	// ring read address: next byte the sequence needs
	always_comb begin
		rd_addr = start_q;
		unique case (state_q)
			ST_IDLE: rd_addr = start_new;
			ST_HEAD: rd_addr = head_is_id ? start_q : start_q + AW'(1);
			ST_CRC: rd_addr = start_q + AW'(next_data_idx);
			ST_CHECK: rd_addr = (crc_q == '0) ? start_q : start_q + AW'(1);
			ST_EMIT: rd_addr = start_q + AW'(idx_q + (out_full ? FW'(0) : FW'(1)));
			default: rd_addr = start_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_avail) state_d = ST_HEAD;
			ST_HEAD: begin
				if (fill_q == '0) state_d = ST_IDLE;
				else if (head_is_id) begin
					if (fill_q < len_eff) state_d = ST_IDLE;
					else state_d = ST_CRC;
				end
			end
			ST_CRC: if (bit_q == 3'd7 && idx_q == crc_total - FW'(1)) state_d = ST_CHECK;
			ST_CHECK: state_d = (crc_q == '0) ? ST_EMIT : ST_HEAD;
			ST_EMIT: if (!out_full && idx_q == len_q - FW'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_take = (state_q == ST_IDLE) && in_avail;
		out_push = (state_q == ST_EMIT);
		out_item.data = rd_q;
		out_item.kind = kind_q;
		out_item.last = (idx_q == len_q - FW'(1));
		busy = (state_q != ST_IDLE);
	end

	logic [FW-1:0] fill_new;
	logic [AW-1:0] start_new;
	always_comb begin
		fill_new = fill_q;
		start_new = start_q;
		if (fill_q >= FW'(MAX_BYTES)) begin
			fill_new = fill_q - FW'(1);
			start_new = start_q + AW'(1);
		end
	end

	// pass the new byte through when it becomes the head of an empty ring
	always_ff @(posedge clk) begin
		if (in_take) ring_q[start_new + AW'(fill_new)] <= in_byte;
		rd_q <= (in_take && fill_new == '0) ? in_byte : ring_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			start_q <= '0;
			crc_q <= CRC_INIT;
			len_q <= '0;
			kind_q <= 1'b0;
			idx_q <= '0;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_take) begin
					fill_q <= fill_new + FW'(1);
					start_q <= start_new;
				end
				ST_HEAD: begin
					if (fill_q != '0) begin
						if (head_is_id) begin
							kind_q <= (rd_q == ID_FULL);
							len_q <= len_eff;
							if (fill_q >= len_eff) begin
								idx_q <= '0;
								bit_q <= '0;
								crc_q <= CRC_INIT;
							end
						end else begin
							fill_q <= fill_q - FW'(1);
							start_q <= start_q + AW'(1);
						end
					end
				end
				ST_CRC: begin
					crc_q <= crc_bit(crc_in);
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) idx_q <= idx_q + FW'(1);
				end
				ST_CHECK: begin
					if (crc_q == '0) idx_q <= '0;
					else begin
						fill_q <= fill_q - FW'(1);
						start_q <= start_q + AW'(1);
					end
				end
				ST_EMIT: if (!out_full) begin
					idx_q <= idx_q + FW'(1);
					if (idx_q == len_q - FW'(1)) begin
						fill_q <= fill_q - len_q;
						start_q <= start_q + AW'(len_q);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

/* hdl/imu_datagram_crc_framer.sv */
// Top level of the IMU datagram CRC framer: config registers, input queue, scanner, result queue.
// Depends on idcf_pkg, idcf_in_fifo, idcf_scanner, idcf_out_fifo.
//
//  channel | handshake          | payload
//  input   | push / full        | rx_byte
//  result  | pop / empty        | datagram_byte, datagram_kind, last_byte
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A byte that finishes nothing passes through the idle and head steps, plus one more head step per discarded head byte.
// A CRC check runs every CRC byte (length + dummy bytes) through the bit-serial loop, then
// a check step; a match then emits one byte per cycle while the result queue has room,
// a mismatch drops the identifier and rescans from the head step.
// Reset clears queues, ring fill and registers to their reset values; ring contents are not
// cleared. Either side may stall: the input queue holds bytes while the scanner works, and
// the scanner holds in the emit step while the result queue is full.
module imu_datagram_crc_framer
	import idcf_pkg::*;
#(
	parameter int MAX_DATAGRAM_BYTES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] rx_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] datagram_byte,
	output logic datagram_kind,
	output logic last_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [6:0] cfg_data
);
	logic [6:0] len_short_q, len_full_q;
	logic [2:0] dummy_q;
	logic fi_empty, take, opush, ofull, busy;
	logic [7:0] fi_data;
	out_item_t oitem, odata;

	assign cfg_ready = 1'b1;

	// config writes; out-of-list indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_short_q <= 7'd40;
			len_full_q <= 7'd44;
			dummy_q <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEN_SHORT: len_short_q <= cfg_data;
				REG_LEN_FULL: len_full_q <= cfg_data;
				REG_DUMMY: dummy_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	idcf_in_fifo #(.DEPTH(4)) u_in (
		.clk, .arst_n, .wr_en(push), .wr_data(rx_byte), .full,
		.rd_en(take), .rd_data(fi_data), .empty(fi_empty)
	);

	idcf_scanner #(.MAX_BYTES(MAX_DATAGRAM_BYTES)) u_scan (
		.clk, .arst_n, .in_avail(!fi_empty), .in_byte(fi_data), .in_take(take),
		.len_short(len_short_q), .len_full(len_full_q), .dummy_cnt(dummy_q),
		.out_push(opush), .out_item(oitem), .out_full(ofull), .busy
	);

	idcf_out_fifo #(.DEPTH(4)) u_out (
		.clk, .arst_n, .wr_en(opush), .wr_data(oitem), .full(ofull),
		.rd_en(pop), .rd_data(odata), .empty
	);

	assign datagram_byte = odata.data;
	assign datagram_kind = odata.kind;
	assign last_byte = odata.last;

`ifndef SYNTH
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy) else $error("byte taken while scanner busy");
	a_take_data: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !fi_empty) else $error("byte taken from empty queue");
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> busy) else $error("result pushed while idle");
`endif
endmodule
